[src/keyed_table_lookup_with_oldest_eviction_defines.svh]
// Assertion macros shared by the lookup table RTL.
`ifndef KEYED_TABLE_LOOKUP_WITH_OLDEST_EVICTION_DEFINES_SVH
`define KEYED_TABLE_LOOKUP_WITH_OLDEST_EVICTION_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KTL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// Consequent must hold in the cycle after the antecedent.
`define KTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

[src/ktl_pkg.sv]
`default_nettype none

package ktl_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int KEY_W         = 48;
    localparam int TIME_W        = 32;
    localparam int SLOT_W        = 5;
    localparam int OUTC_W        = 2;
    localparam int BYTE_W        = 8;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [TIME_W-1:0] time_t;

    typedef enum logic [OUTC_W-1:0] {
        OUTC_HIT   = 2'd0,
        OUTC_FREE  = 2'd1,
        OUTC_EVICT = 2'd2
    } outcome_t;

    typedef struct packed {
        logic clear;
        logic valid;
        idx_t idx;
    } scan_ctrl_t;

    typedef struct packed {
        idx_t     slot;
        outcome_t outcome;
        key_t     evicted;
    } scan_res_t;

endpackage

`default_nettype wire

[src/keyed_table_lookup_with_oldest_eviction.sv]
// Device table lookup with oldest-entry eviction.
// Input channel: in_valid, in_stall, device_key, now_time. A beat is taken
// when in_valid is high and in_stall is low; in_stall is low only while the
// block is idle.
// Output channel: out_valid, out_stall, slot_index, outcome, evicted_key. One
// result beat follows every input beat, held stable while out_stall is high.
// Each beat scans every table entry through one read port and one compare
// unit, one entry per cycle, then passes through the drain and done states
// before the result is loaded; in_stall stays high meanwhile, so the next
// beat can be taken on the cycle after the result is loaded.
// A waiting result does not block a new input beat; the new item holds in its
// final cycle until the output register is free, and only then updates the
// table.
// Reset clears the table and all handshake state at once; no clearing pass is
// needed and a beat can be taken on the first cycle after reset.
`default_nettype none
`include "keyed_table_lookup_with_oldest_eviction_defines.svh"

module keyed_table_lookup_with_oldest_eviction
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ktl_pkg::KEY_W-1:0]     device_key,
    input  wire logic [ktl_pkg::TIME_W-1:0]    now_time,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ktl_pkg::SLOT_W-1:0]         slot_index,
    output logic [ktl_pkg::OUTC_W-1:0]         outcome,
    output logic [ktl_pkg::KEY_W-1:0]          evicted_key
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    localparam ktl_pkg::idx_t LAST_IDX = ktl_pkg::IDX_W'(ktl_pkg::TABLE_ENTRIES - 1);

    state_t         state_reg,  state_next;
    ktl_pkg::idx_t  cnt_reg,    cnt_next;
    ktl_pkg::key_t  key_reg,    key_next;
    ktl_pkg::time_t time_reg,   time_next;
    logic           out_valid_reg, out_valid_next;
    logic [ktl_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic [ktl_pkg::OUTC_W-1:0] outc_reg, outc_next;
    ktl_pkg::key_t  evict_reg,  evict_next;

    ktl_pkg::scan_ctrl_t scan_ctrl;
    ktl_pkg::scan_res_t  scan_res;
    ktl_pkg::key_t       rd_key;
    ktl_pkg::time_t      rd_time;
    logic                wr_en;
    logic                out_free;
    logic                in_accept;
    logic [ktl_pkg::IDX_W+ktl_pkg::SLOT_W-1:0] slot_wide;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign slot_wide = {{ktl_pkg::SLOT_W{1'b0}}, scan_res.slot};

    ktl_table u_table
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (cnt_reg),
        .wr_en   (wr_en),
        .wr_addr (scan_res.slot),
        .wr_key  (key_reg),
        .wr_time (time_reg),
        .rd_key  (rd_key),
        .rd_time (rd_time)
    );

    ktl_scan u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .search_key (key_reg),
        .rd_key     (rd_key),
        .rd_time    (rd_time),
        .res        (scan_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        key_next        = key_reg;
        time_next       = time_reg;
        out_valid_next  = out_valid_reg;
        slot_next       = slot_reg;
        outc_next       = outc_reg;
        evict_next      = evict_reg;
        scan_ctrl.clear = 1'b0;
        scan_ctrl.valid = 1'b0;
        scan_ctrl.idx   = cnt_reg;
        wr_en           = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = device_key;
                    time_next       = now_time;
                    cnt_next        = '0;
                    scan_ctrl.clear = 1'b1;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_ctrl.valid = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    slot_next      = slot_wide[ktl_pkg::SLOT_W-1:0];
                    outc_next      = scan_res.outcome;
                    evict_next     = scan_res.evicted;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        time_reg  <= time_next;
        slot_reg  <= slot_next;
        outc_reg  <= outc_next;
        evict_reg <= evict_next;
    end

    assign out_valid   = out_valid_reg;
    assign slot_index  = slot_reg;
    assign outcome     = outc_reg;
    assign evicted_key = evict_reg;

    `KTL_ASSERT_NEXT(a_accept_starts_scan, clk, rst_n, in_accept, (state_reg == ST_SCAN) && (cnt_reg == '0))
    `KTL_ASSERT_NEXT(a_done_loads_result, clk, rst_n, (state_reg == ST_DONE) && out_free, out_valid && (state_reg == ST_IDLE))
    `KTL_ASSERT_SAME(a_evict_key_zero, clk, rst_n, out_valid && (outcome != ktl_pkg::OUTC_EVICT), evicted_key == '0)
    `KTL_ASSERT_SAME(a_write_only_done, clk, rst_n, wr_en, (state_reg == ST_DONE) && out_free)

endmodule

`default_nettype wire

[src/ktl_table.sv]
`default_nettype none

module ktl_table
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ktl_pkg::idx_t rd_addr,
    input  wire logic          wr_en,
    input  wire ktl_pkg::idx_t wr_addr,
    input  wire ktl_pkg::key_t wr_key,
    input  wire ktl_pkg::time_t wr_time,
    output ktl_pkg::key_t      rd_key,
    output ktl_pkg::time_t     rd_time
);

    ktl_pkg::key_t  mem_key  [ktl_pkg::TABLE_ENTRIES];
    ktl_pkg::time_t mem_time [ktl_pkg::TABLE_ENTRIES];
    logic [ktl_pkg::TABLE_ENTRIES-1:0] valid_reg;
    ktl_pkg::key_t  rd_key_reg;
    ktl_pkg::time_t rd_time_reg;

    // Entries that have never been written read back as the cleared value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_key[wr_addr]  <= wr_key;
            mem_time[wr_addr] <= wr_time;
        end
        if (valid_reg[rd_addr])
        begin
            rd_key_reg  <= mem_key[rd_addr];
            rd_time_reg <= mem_time[rd_addr];
        end
        else
        begin
            rd_key_reg  <= '0;
            rd_time_reg <= '0;
        end
    end

    assign rd_key  = rd_key_reg;
    assign rd_time = rd_time_reg;

endmodule

`default_nettype wire

[src/ktl_scan.sv]
`default_nettype none

module ktl_scan
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ktl_pkg::scan_ctrl_t ctrl,
    input  wire ktl_pkg::key_t       search_key,
    input  wire ktl_pkg::key_t       rd_key,
    input  wire ktl_pkg::time_t      rd_time,
    output ktl_pkg::scan_res_t       res
);

    logic           pipe_vld_reg;
    ktl_pkg::idx_t  pipe_idx_reg;
    logic           hit_found_reg;
    ktl_pkg::idx_t  hit_idx_reg;
    logic           free_found_reg;
    ktl_pkg::idx_t  free_idx_reg;
    ktl_pkg::time_t old_time_reg;
    ktl_pkg::idx_t  old_idx_reg;
    ktl_pkg::key_t  old_key_reg;

    logic is_hit;
    logic is_free;
    logic is_older;

    assign is_hit   = (rd_key == search_key);
    assign is_free  = (rd_key[ktl_pkg::KEY_W-1 -: ktl_pkg::BYTE_W] == '0);
    assign is_older = (pipe_idx_reg == '0) || (rd_time < old_time_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pipe_vld_reg   <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= ctrl.valid;
            if (ctrl.clear)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (pipe_vld_reg)
            begin
                if (is_hit && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (is_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // The first entry always seeds the oldest candidate, so a table full of
    // maximum times evicts entry zero.
    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= ctrl.idx;
        if (pipe_vld_reg)
        begin
            if (is_hit && !hit_found_reg)
            begin
                hit_idx_reg <= pipe_idx_reg;
            end
            if (is_free && !free_found_reg)
            begin
                free_idx_reg <= pipe_idx_reg;
            end
            if (is_older)
            begin
                old_time_reg <= rd_time;
                old_idx_reg  <= pipe_idx_reg;
                old_key_reg  <= rd_key;
            end
        end
    end

    always_comb
    begin
        if (hit_found_reg)
        begin
            res.slot    = hit_idx_reg;
            res.outcome = ktl_pkg::OUTC_HIT;
            res.evicted = '0;
        end
        else if (free_found_reg)
        begin
            res.slot    = free_idx_reg;
            res.outcome = ktl_pkg::OUTC_FREE;
            res.evicted = '0;
        end
        else
        begin
            res.slot    = old_idx_reg;
            res.outcome = ktl_pkg::OUTC_EVICT;
            res.evicted = old_key_reg;
        end
    end

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import ktl_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int TOTAL_ITEMS  = 1050;
    localparam int QUIET_ITEMS  = 150;
    localparam int RECENT_DEPTH = 40;

    typedef enum int {
        STAMP_STEADY,
        STAMP_COARSE,
        STAMP_SATURATED,
        STAMP_SCATTERED
    } stamp_mode_t;

    typedef struct {
        key_t  key;
        time_t stamp;
        bit    hold;
    } sighting_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        outcome_t          outc;
        key_t              evicted;
    } lookup_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [KEY_W-1:0]  device_key = '0;
    logic [TIME_W-1:0] now_time = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [SLOT_W-1:0] slot_index;
    logic [OUTC_W-1:0] outcome;
    logic [KEY_W-1:0]  evicted_key;

    sighting_t      sighting_q[$];
    lookup_result_t lookup_expect_q[$];
    key_t           recent_keys[$];
    key_t           table_key[TABLE_ENTRIES];
    time_t          table_stamp[TABLE_ENTRIES];
    time_t          stamp_clock = '0;
    int             send_gap = 0;
    int             stall_left = 0;
    int             idle_cycles = 0;
    int             failures = 0;

    keyed_table_lookup_with_oldest_eviction dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .device_key  (device_key),
        .now_time    (now_time),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .slot_index  (slot_index),
        .outcome     (outcome),
        .evicted_key (evicted_key)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic lookup_result_t resolve_entry(key_t key, time_t stamp);
        lookup_result_t r;
        int             chosen;
        bit             found;
        time_t          oldest;
        chosen    = 0;
        found     = 1'b0;
        r.outc    = OUTC_HIT;
        r.evicted = '0;
        for (int i = 0; i < TABLE_ENTRIES && !found; i++)
        begin
            if (table_key[i] == key)
            begin
                chosen = i;
                found  = 1'b1;
            end
        end
        for (int i = 0; i < TABLE_ENTRIES && !found; i++)
        begin
            if (table_key[i][KEY_W-1 -: BYTE_W] == '0)
            begin
                chosen = i;
                found  = 1'b1;
                r.outc = OUTC_FREE;
            end
        end
        if (!found)
        begin
            oldest = '1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                if (table_stamp[i] < oldest)
                begin
                    oldest = table_stamp[i];
                    chosen = i;
                end
            end
            r.outc    = OUTC_EVICT;
            r.evicted = table_key[chosen];
        end
        table_key[chosen]   = key;
        table_stamp[chosen] = stamp;
        r.slot = chosen[SLOT_W-1:0];
        return r;
    endfunction

    task automatic push_sighting(key_t key, time_t stamp, bit hold);
        sighting_t s;
        s.key   = key;
        s.stamp = stamp;
        s.hold  = hold;
        sighting_q.push_back(s);
        recent_keys.push_back(key);
        if (recent_keys.size() > RECENT_DEPTH)
            void'(recent_keys.pop_front());
    endtask

    task automatic plan_episode(stamp_mode_t mode, int count, int fresh_pct);
        key_t  key;
        time_t stamp;
        int    pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            key[31:0]  = $urandom;
            key[47:32] = 16'($urandom_range(0, 65535));
            if (pick < fresh_pct)
                key[47:40] = 8'($urandom_range(1, 255));
            else if (pick < 92)
                key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            else if (pick < 98)
                key[47:40] = '0;
            else
                key = ($urandom_range(0, 1) == 1) ? '1 : '0;
            case (mode)
                STAMP_STEADY:
                begin
                    stamp_clock += $urandom_range(1, 1000);
                    stamp = stamp_clock;
                end
                STAMP_COARSE:
                begin
                    if ($urandom_range(0, 3) == 0)
                        stamp_clock++;
                    stamp = stamp_clock;
                end
                STAMP_SATURATED:
                    stamp = '1;
                default:
                    stamp = $urandom;
            endcase
            push_sighting(key, stamp, 1'b0);
        end
    endtask

    // Directed part: the zero key hitting a cleared entry, free entries that
    // still hold low address bytes, and the field extremes.
    initial
    begin
        int episode;
        foreach (table_key[i])
        begin
            table_key[i]   = '0;
            table_stamp[i] = '0;
        end
        push_sighting(48'h0000_0000_0000, 32'h0000_0000, 1'b0);
        push_sighting(48'h0000_0000_1234, 32'h0000_0005, 1'b0);
        push_sighting(48'h00FF_FFFF_FFFF, 32'h0000_0009, 1'b0);
        push_sighting(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        push_sighting(48'h0000_0000_0000, 32'h0000_0001, 1'b0);
        push_sighting(48'hFFFF_FFFF_FFFF, 32'h0000_0003, 1'b0);
        push_sighting(48'h0100_0000_0000, 32'h0000_0000, 1'b0);
        push_sighting(48'h8000_0000_0001, 32'h8000_0000, 1'b1);
        push_sighting(48'h0000_0000_0000, 32'h0000_0002, 1'b0);
        push_sighting(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 1'b0);
        push_sighting(48'h5555_5555_5555, 32'hAAAA_AAAA, 1'b0);
        push_sighting(48'h0100_0000_0000, 32'h0000_0007, 1'b0);
        push_sighting(48'h0000_0000_0001, 32'hFFFF_FFFE, 1'b0);
        push_sighting(48'hFF00_0000_0000, 32'h0000_0001, 1'b0);
        plan_episode(STAMP_COARSE, 80, 85);
        plan_episode(STAMP_SATURATED, 80, 85);
        episode = 0;
        while (sighting_q.size() < TOTAL_ITEMS)
        begin
            if (episode == 5)
                push_sighting(48'h0100_0000_0000, stamp_clock, 1'b1);
            plan_episode(stamp_mode_t'($urandom_range(0, 3)), $urandom_range(20, 80),
                         $urandom_range(20, 70));
            episode++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (sighting_q.size() != 0 || in_valid || lookup_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : sender
        sighting_t s;
        bit        launch;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            device_key <= '0;
            now_time   <= '0;
            send_gap   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                lookup_expect_q.push_back(resolve_entry(device_key, now_time));
            if (!(in_valid && in_stall))
            begin
                launch = 1'b0;
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
                else if (sighting_q.size() != 0
                         && !(sighting_q[0].hold && lookup_expect_q.size() != 0))
                begin
                    if (sighting_q.size() > QUIET_ITEMS && $urandom_range(0, 3) == 0)
                        send_gap <= $urandom_range(0, 18);
                    else
                        launch = 1'b1;
                end
                if (launch)
                begin
                    s = sighting_q.pop_front();
                    device_key <= s.key;
                    now_time   <= s.stamp;
                end
                in_valid <= launch;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        lookup_result_t due;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (lookup_expect_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing pending: slot %0d outcome %0d "
                             , $time, slot_index, outcome, "evicted %h", evicted_key);
                    failures++;
                end
                else
                begin
                    due = lookup_expect_q.pop_front();
                    if (slot_index !== due.slot)
                    begin
                        $display("%0t: slot_index expected %0d, actual %0d",
                                 $time, due.slot, slot_index);
                        failures++;
                    end
                    if (outcome !== due.outc)
                    begin
                        $display("%0t: outcome expected %0d, actual %0d",
                                 $time, due.outc, outcome);
                        failures++;
                    end
                    if (evicted_key !== due.evicted)
                    begin
                        $display("%0t: evicted_key expected %h, actual %h",
                                 $time, due.evicted, evicted_key);
                        failures++;
                    end
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (sighting_q.size() > QUIET_ITEMS && $urandom_range(0, 11) == 0)
            begin
                stall_left <= $urandom_range(0, 18);
                out_stall  <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
